// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that an implication holds at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

// Assert that an implication holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

// File: rtl/core/lsnh_pkg.sv
package lsnh_pkg;
	localparam int MaxNodes = 16;
	localparam int NodeBits = 4;
	localparam int EdgeBits = 8;
	localparam int CostBits = 16;
	localparam int DistBits = 24;
	localparam logic [DistBits-1:0] InfDist = 24'd1000000;
	localparam logic OpUpdate = 1'b0;
	localparam logic OpQuery = 1'b1;
	localparam logic [1:0] RegSelfNode = 2'd0;

	typedef struct packed {
		logic operation;
		logic [3:0] link_src;
		logic [3:0] link_dst;
		logic [15:0] link_cost;
		logic [15:0] link_age;
		logic [3:0] query_node;
	} in_item_t;

	typedef struct packed {
		logic flood;
		logic [3:0] flood_except;
		logic [3:0] next_hop;
		logic reachable;
	} out_item_t;

	// Start request and completion status between the top level and the search engine.
	typedef struct packed {
		logic start;
		logic [NodeBits-1:0] root;
		logic [NodeBits-1:0] target;
	} srch_req_t;

	typedef struct packed {
		logic done;
		logic reachable;
		logic [NodeBits-1:0] hop;
	} srch_rsp_t;
endpackage

// File: rtl/core/link_state_next_hop.sv
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_ready  lsnh_pkg::in_item_t
// out       output     out_valid/out_ready lsnh_pkg::out_item_t
// apb       input      psel/penable       self_node at address 0
// An update steps through a read of the edge memory, a compare and write, and the result.
// A query for the own node is answered in the cycle after it is accepted. Any other
// query runs the node scan and the relax sweep in turn for each settled node, one memory
// entry read per cycle, and then ends with the parent walk to the first hop.
// The block works on one item at a time; in_ready is low while an item is busy
// or its result waits. Reset clears the edge valid bits at once, no sweep.
module link_state_next_hop (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input lsnh_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_ready,
	output lsnh_pkg::out_item_t out_item,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import lsnh_pkg::*;
	`include "assert_macros.svh"

	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StUpdRd = 3'd1;
	localparam logic [2:0] StUpdWr = 3'd2;
	localparam logic [2:0] StSearch = 3'd3;
	localparam logic [2:0] StOut = 3'd4;

	logic [2:0] state_q;
	logic [NodeBits-1:0] self_q;
	in_item_t item_q;
	out_item_t res_q;

	// The edge store: cost and age in one memory, valid bits in flip-flops.
	logic [2*CostBits-1:0] edge_mem [MaxNodes*MaxNodes];
	logic [2*CostBits-1:0] edge_rd_q;
	logic [MaxNodes*MaxNodes-1:0] present_q;
	logic present_rd_q;
	logic [EdgeBits-1:0] edge_addr, srch_addr;
	logic edge_we;
	srch_req_t req;
	srch_rsp_t rsp;
	logic accept_upd;

	assign pready = 1'b1;
	assign prdata = {28'd0, self_q};
	assign in_ready = (state_q == StIdle);
	assign out_valid = (state_q == StOut);
	assign out_item = res_q;

	assign edge_addr = (state_q == StSearch) ? srch_addr : {item_q.link_src, item_q.link_dst};
	assign accept_upd = !present_rd_q || (item_q.link_age > edge_rd_q[CostBits-1:0]);
	assign edge_we = (state_q == StUpdWr) && accept_upd;

	always_ff @(posedge clk) begin
		if (edge_we) begin
			edge_mem[edge_addr] <= {item_q.link_cost, item_q.link_age};
		end
		edge_rd_q <= edge_mem[edge_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			present_rd_q <= 1'b0;
		end else begin
			present_rd_q <= present_q[edge_addr];
			if (edge_we) begin
				present_q[edge_addr] <= 1'b1;
			end
		end
	end

	always_comb begin
		req.start = (state_q == StSearch) && !rsp.done;
		req.root = self_q;
		req.target = item_q.query_node;
	end

	lsnh_search u_search (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.edge_raddr(srch_addr),
		.edge_rcost(edge_rd_q[2*CostBits-1:CostBits]),
		.edge_rpresent(present_rd_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			self_q <= '0;
		end else begin
			if (psel && penable && pwrite && paddr == RegSelfNode) begin
				self_q <= pwdata[NodeBits-1:0];
			end
			case (state_q)
				StIdle: begin
					if (in_valid) begin
						item_q <= in_item;
						res_q <= '0;
						if (in_item.operation == OpUpdate) begin
							state_q <= StUpdRd;
						end else if (in_item.query_node == self_q) begin
							res_q.next_hop <= self_q;
							res_q.reachable <= 1'b1;
							state_q <= StOut;
						end else begin
							state_q <= StSearch;
						end
					end
				end
				StUpdRd: state_q <= StUpdWr;
				StUpdWr: begin
					if (accept_upd) begin
						res_q.flood <= 1'b1;
						res_q.flood_except <= item_q.link_src;
					end
					state_q <= StOut;
				end
				StSearch: begin
					if (rsp.done) begin
						res_q.next_hop <= rsp.hop;
						res_q.reachable <= rsp.reachable;
						state_q <= StOut;
					end
				end
				StOut: begin
					if (out_ready) begin
						state_q <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	`ASSERT_IMPL(a_no_flood_on_query, clk, arst_n, out_valid && item_q.operation == OpQuery, !out_item.flood)
	`ASSERT_NEXT(a_result_held, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_item))
	`ASSERT_IMPL(a_busy_not_ready, clk, arst_n, state_q != StIdle, !in_ready)
endmodule

// File: rtl/core/lsnh_search.sv
module lsnh_search (
	input logic clk,
	input logic arst_n,
	input lsnh_pkg::srch_req_t req,
	output lsnh_pkg::srch_rsp_t rsp,
	output logic [lsnh_pkg::EdgeBits-1:0] edge_raddr,
	input logic [lsnh_pkg::CostBits-1:0] edge_rcost,
	input logic edge_rpresent
);
	import lsnh_pkg::*;

	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StInit = 3'd1;
	localparam logic [2:0] StScan = 3'd2;
	localparam logic [2:0] StRelax = 3'd3;
	localparam logic [2:0] StWalk = 3'd4;
	localparam logic [2:0] StDone = 3'd5;

	logic [2:0] state_q;
	logic [NodeBits:0] idx_q;
	logic [NodeBits-1:0] root_q, target_q, u_q, hop_q;
	logic [DistBits-1:0] best_q;
	logic found_q;
	logic [MaxNodes-1:0] done_q;
	logic rd_valid_s1;
	logic [NodeBits-1:0] rd_node_s1;

	// Distance and parent scratch memories, one write port and one read port each, registered read.
	logic [DistBits-1:0] dist_mem [MaxNodes];
	logic [NodeBits-1:0] par_mem [MaxNodes];
	logic [DistBits-1:0] dist_rd_q;
	logic [NodeBits-1:0] par_rd_q;
	logic dist_we, par_we;
	logic [NodeBits-1:0] dist_waddr, dist_raddr, par_waddr, par_raddr;
	logic [DistBits-1:0] dist_wdata;
	logic [NodeBits-1:0] par_wdata;
	logic [DistBits:0] nd_sum;
	logic [DistBits-1:0] nd;

	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem[dist_waddr] <= dist_wdata;
		end
		dist_rd_q <= dist_mem[dist_raddr];
		if (par_we) begin
			par_mem[par_waddr] <= par_wdata;
		end
		par_rd_q <= par_mem[par_raddr];
	end

	assign nd_sum = {1'b0, best_q} + {{(DistBits+1-CostBits){1'b0}}, edge_rcost};
	assign nd = (nd_sum > {1'b0, InfDist}) ? InfDist : nd_sum[DistBits-1:0];

	always_comb begin
		dist_raddr = idx_q[NodeBits-1:0];
		par_raddr = hop_q;
		edge_raddr = {u_q, idx_q[NodeBits-1:0]};
		dist_we = 1'b0;
		dist_waddr = idx_q[NodeBits-1:0];
		dist_wdata = InfDist;
		par_we = 1'b0;
		par_waddr = idx_q[NodeBits-1:0];
		par_wdata = '0;
		case (state_q)
			StInit: begin
				dist_we = 1'b1;
				par_we = 1'b1;
				if (idx_q[NodeBits-1:0] == root_q) begin
					dist_wdata = '0;
					par_wdata = root_q;
				end
			end
			StRelax: begin
				dist_waddr = rd_node_s1;
				par_waddr = rd_node_s1;
				dist_wdata = nd;
				par_wdata = u_q;
				if (rd_valid_s1 && edge_rpresent && !done_q[rd_node_s1] && nd < dist_rd_q) begin
					dist_we = 1'b1;
					par_we = 1'b1;
				end
			end
			StWalk: begin
				// The reachability check needs the target's distance.
				dist_raddr = target_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			idx_q <= '0;
			rd_valid_s1 <= 1'b0;
			done_q <= '0;
			found_q <= 1'b0;
		end else begin
			rd_valid_s1 <= 1'b0;
			rd_node_s1 <= idx_q[NodeBits-1:0];
			case (state_q)
				StIdle: begin
					if (req.start) begin
						root_q <= req.root;
						target_q <= req.target;
						idx_q <= '0;
						state_q <= StInit;
					end
				end
				StInit: begin
					done_q <= '0;
					if (idx_q == (NodeBits+1)'(MaxNodes-1)) begin
						idx_q <= '0;
						best_q <= InfDist;
						found_q <= 1'b0;
						state_q <= StScan;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				StScan: begin
					// Read one distance a cycle; compare it in the next cycle.
					if (idx_q != (NodeBits+1)'(MaxNodes)) begin
						idx_q <= idx_q + 1'b1;
						rd_valid_s1 <= 1'b1;
					end
					if (rd_valid_s1 && !done_q[rd_node_s1] && dist_rd_q < best_q) begin
						best_q <= dist_rd_q;
						u_q <= rd_node_s1;
						found_q <= 1'b1;
					end
					if (!rd_valid_s1 && idx_q == (NodeBits+1)'(MaxNodes)) begin
						idx_q <= '0;
						if (found_q) begin
							done_q[u_q] <= 1'b1;
							state_q <= StRelax;
						end else begin
							hop_q <= target_q;
							state_q <= StWalk;
							rd_valid_s1 <= 1'b0;
						end
					end
				end
				StRelax: begin
					// Distances written here belong to distinct nodes, so no
					// read of the same entry is in flight.
					if (idx_q != (NodeBits+1)'(MaxNodes)) begin
						idx_q <= idx_q + 1'b1;
						rd_valid_s1 <= 1'b1;
					end else if (!rd_valid_s1) begin
						idx_q <= '0;
						best_q <= InfDist;
						found_q <= 1'b0;
						state_q <= StScan;
					end
				end
				StWalk: begin
					// First cycle reads the target distance; then the parent chain.
					// idx_q counts the steps and bounds the walk.
					if (!rd_valid_s1) begin
						rd_valid_s1 <= 1'b1;
					end else if (idx_q == '0 && !found_q) begin
						found_q <= 1'b1;
						idx_q <= idx_q + 1'b1;
						if (dist_rd_q >= InfDist) begin
							state_q <= StDone;
						end
						rd_valid_s1 <= 1'b0;
					end else begin
						rd_valid_s1 <= 1'b0;
						if (par_rd_q == root_q || idx_q == (NodeBits+1)'(MaxNodes)) begin
							state_q <= StDone;
						end else begin
							hop_q <= par_rd_q;
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				StDone: begin
					state_q <= StIdle;
					found_q <= 1'b0;
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	// In the walk, found_q marks that the target distance check has been made.
	logic reach_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reach_q <= 1'b0;
		end else if (state_q == StWalk && rd_valid_s1 && idx_q == '0 && !found_q) begin
			reach_q <= (dist_rd_q < InfDist);
		end
	end

	always_comb begin
		rsp.done = (state_q == StDone);
		rsp.reachable = reach_q;
		rsp.hop = reach_q ? hop_q : '0;
	end
endmodule

// File: tb/sv/tb_link_state_next_hop.sv
module tb_link_state_next_hop;
	import lsnh_pkg::*;

	// Topology table, shortest path search and the results it predicts.
	class route_scoreboard;
		logic [15:0] cost_tab[256];
		logic [15:0] age_tab[256];
		bit          link_up[256];
		logic [3:0]  root_node;
		out_item_t   pending[$];
		int          errors;
		int          n_update, n_flood, n_query, n_reach;

		function new();
			for (int e = 0; e < 256; e++) begin
				cost_tab[e] = '0;
				age_tab[e] = '0;
				link_up[e] = 0;
			end
			root_node = '0;
			errors = 0;
			n_update = 0;
			n_flood = 0;
			n_query = 0;
			n_reach = 0;
		endfunction

		task report(string what, int got, int want);
			errors++;
			$display("ERROR: %s got %0d expected %0d", what, got, want);
		endtask

		// Dijkstra from the root; returns the first hop toward the target.
		function automatic out_item_t next_hop_search(logic [3:0] target);
			int unsigned path_dist[16];
			int unsigned parent[16];
			bit          done[16];
			int unsigned best, nd;
			int          u, hop;
			bit          found;
			out_item_t   r;
			r = '0;
			if (target == root_node) begin
				r.next_hop = root_node;
				r.reachable = 1'b1;
				return r;
			end
			for (int i = 0; i < 16; i++) begin
				path_dist[i] = 1000000;
				parent[i] = 0;
				done[i] = 0;
			end
			path_dist[root_node] = 0;
			parent[root_node] = root_node;
			for (int k = 0; k < 16; k++) begin
				best = 1000000;
				found = 0;
				u = 0;
				for (int i = 0; i < 16; i++) begin
					if (!done[i] && path_dist[i] < best) begin
						best = path_dist[i];
						u = i;
						found = 1;
					end
				end
				if (!found)
					break;
				done[u] = 1;
				for (int v = 0; v < 16; v++) begin
					if (link_up[u*16+v] && !done[v]) begin
						nd = best + cost_tab[u*16+v];
						if (nd > 1000000)
							nd = 1000000;
						if (nd < path_dist[v]) begin
							path_dist[v] = nd;
							parent[v] = u;
						end
					end
				end
			end
			if (path_dist[target] >= 1000000)
				return r;
			hop = int'(target);
			for (int k = 0; k < 16; k++) begin
				if (parent[hop] == root_node)
					break;
				hop = parent[hop];
			end
			r.next_hop = hop[3:0];
			r.reachable = 1'b1;
			return r;
		endfunction

		function void note_item(in_item_t it);
			out_item_t r;
			int        e;
			r = '0;
			if (it.operation == OpUpdate) begin
				n_update++;
				e = int'({it.link_src, it.link_dst});
				if (!link_up[e] || it.link_age > age_tab[e]) begin
					cost_tab[e] = it.link_cost;
					age_tab[e] = it.link_age;
					link_up[e] = 1;
					r.flood = 1'b1;
					r.flood_except = it.link_src;
					n_flood++;
				end
			end else begin
				n_query++;
				r = next_hop_search(it.query_node);
				if (r.reachable)
					n_reach++;
			end
			pending.push_back(r);
		endfunction

		task check_result(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				report("unexpected item", 1, 0);
				return;
			end
			want = pending[0];
			pending.delete(0);
			if (got.flood !== want.flood)
				report("flood", got.flood, want.flood);
			if (got.flood_except !== want.flood_except)
				report("flood_except", got.flood_except, want.flood_except);
			if (got.next_hop !== want.next_hop)
				report("next_hop", got.next_hop, want.next_hop);
			if (got.reachable !== want.reachable)
				report("reachable", got.reachable, want.reachable);
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_item;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_item;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	route_scoreboard sb;
	int idle_cycles;

	link_state_next_hop uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Gap length: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50)
			return 0;
		if (p < 90)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// Offer one item and hold it until the block takes it, then maybe idle.
	task send_item(in_item_t it);
		int gap;
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_item(it);
		idle_cycles = 0;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Build an item from its fields; the unused fields get random filler so that
	// the block is seen to ignore them.
	function automatic in_item_t make_update(int s, int d, int c, int a);
		in_item_t it;
		it.operation = OpUpdate;
		it.link_src = s[3:0];
		it.link_dst = d[3:0];
		it.link_cost = c[15:0];
		it.link_age = a[15:0];
		it.query_node = 4'($urandom_range(0, 15));
		return it;
	endfunction

	function automatic in_item_t make_query(int q);
		in_item_t it;
		it.operation = OpQuery;
		it.link_src = 4'($urandom_range(0, 15));
		it.link_dst = 4'($urandom_range(0, 15));
		it.link_cost = 16'($urandom_range(0, 65535));
		it.link_age = 16'($urandom_range(0, 65535));
		it.query_node = q[3:0];
		return it;
	endfunction

	// The self node register is only touched while nothing is in flight.
	// A read follows each write to check the stored value.
	task set_self_node(int node);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= RegSelfNode;
		pwdata <= {$urandom_range(0, 1) ? 28'hfffffff : 28'h0, node[3:0]};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		sb.root_node = node[3:0];
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[3:0] !== node[3:0])
			sb.report("self_node readback", prdata[3:0], node);
		psel <= 1'b0;
		penable <= 1'b0;
		idle_cycles = 0;
	endtask

	// Random ages lean toward a narrow band so that stale updates are common.
	function automatic int pick_age();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50)
			return $urandom_range(0, 255);
		if (p < 60)
			return 65535;
		if (p < 70)
			return 0;
		return $urandom_range(0, 65535);
	endfunction

	function automatic int pick_cost();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60)
			return $urandom_range(0, 40);
		if (p < 75)
			return 65535;
		return $urandom_range(0, 65535);
	endfunction

	// The receiver stalls at random, in runs of varying length.
	initial begin
		int stall;
		stall = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				sb.check_result(out_item);
				idle_cycles = 0;
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 99) < 30) begin
				stall = pick_gap();
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: queries and gaps are bounded, so a long stretch with no handshake at all
	// means the block is stuck.
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			idle_cycles++;
			if (idle_cycles >= 20000) begin
				$display("timeout after %0d idle cycles", idle_cycles);
				$display("link_state_next_hop: mismatch");
				$finish;
			end
		end
	end

	initial begin
		int top_node [6];
		int self_set [6];
		int q;
		sb = new();
		in_valid = 1'b0;
		in_item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: absent link, equal and older ages, newer age, query for self,
		// an unreachable node, equal-cost paths and the field extremes.
		set_self_node(0);
		send_item(make_query(1));
		send_item(make_query(0));
		send_item(make_update(0, 1, 0, 0));
		send_item(make_update(0, 1, 5, 0));
		send_item(make_update(0, 1, 5, 1));
		send_item(make_update(0, 1, 7, 0));
		send_item(make_query(1));
		send_item(make_update(1, 2, 0, 65535));
		send_item(make_update(0, 4, 2, 3));
		send_item(make_update(4, 2, 3, 3));
		send_item(make_query(2));
		send_item(make_update(0, 4, 9, 65535));
		send_item(make_query(2));
		send_item(make_update(15, 15, 65535, 65535));
		send_item(make_update(2, 15, 65535, 12));
		send_item(make_query(15));
		send_item(make_query(14));
		send_item(make_update(15, 0, 65535, 0));
		set_self_node(15);
		send_item(make_query(15));
		send_item(make_query(0));
		send_item(make_query(2));

		// Random phases: the node set grows, so early on many queries miss, and
		// the self node walks through low, high and random values.
		top_node = '{3, 5, 7, 10, 13, 15};
		self_set = '{0, 3, $urandom_range(0, 7), 15, $urandom_range(0, 15), 15};
		for (int ph = 0; ph < 6; ph++) begin
			set_self_node(self_set[ph]);
			for (int n = 0; n < 205; n++) begin
				if ($urandom_range(0, 99) < 60) begin
					send_item(make_update($urandom_range(0, top_node[ph]),
						$urandom_range(0, top_node[ph]), pick_cost(), pick_age()));
				end else begin
					q = ($urandom_range(0, 9) == 0) ? self_set[ph] : $urandom_range(0, 15);
					send_item(make_query(q));
				end
			end
		end
		in_valid <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("covered %0d updates (%0d flooded) and %0d queries (%0d reachable)",
			sb.n_update, sb.n_flood, sb.n_query, sb.n_reach);
		$display("self node moved through 0, 3, 15 and random values; %0d errors", sb.errors);
		if (sb.errors == 0)
			$display("link_state_next_hop: match");
		else
			$display("link_state_next_hop: mismatch");
		$finish;
	end
endmodule
